>>> rtl/core/mersenne_twister_generator_assert.svh
// ----------------------------------------------------------------------------
// mersenne_twister_generator_assert.svh
// assertion macros used by the generator rtl
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_ASSERT_SVH

// same-cycle implication, checked on clk and off during reset
`define MTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and off during reset
`define MTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_pkg
// constants and shared types of the mt19937 generator
// ----------------------------------------------------------------------------
package mtg_pkg;

  // ring geometry
  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned POS_W         = $clog2(STATE_WORDS);
  localparam int unsigned WORD_W        = 32;

  // burst limits
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned BURST_W   = 7;

  // generator constants
  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;
  localparam int unsigned       SEED_SHIFT   = 30;

  // ring write request
  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

endpackage

>>> rtl/core/mtg_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_ring_mem
// state ring: one write port, two registered read ports
// ----------------------------------------------------------------------------
module mtg_ring_mem
  import mtg_pkg::*;
(
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic              rd_en,
  input  logic [POS_W-1:0]  rd_addr_a,
  input  logic [POS_W-1:0]  rd_addr_b,
  output logic [WORD_W-1:0] rd_data_a,
  output logic [WORD_W-1:0] rd_data_b
);

  logic [WORD_W-1:0] mem [STATE_WORDS];
  logic [WORD_W-1:0] rd_data_a_r;
  logic [WORD_W-1:0] rd_data_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read ports, data held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

>>> rtl/core/mtg_seed_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_seed_unit
// fills the ring from a seed with the knuth initialisation recurrence
// ----------------------------------------------------------------------------
module mtg_seed_unit
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] seed,
  output mem_wr_t           wr,
  output logic              done
);

  typedef enum logic [2:0] {
    SD_IDLE = 3'b001,
    SD_MUL  = 3'b010,
    SD_ADD  = 3'b100
  } sd_state_t;

  sd_state_t         state_r, state_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] entry;
  logic              last_entry;

  // one multiply per entry, the index is added in the following cycle
  assign mix        = prev_r ^ (prev_r >> SEED_SHIFT);
  assign entry      = prod_r + WORD_W'(idx_r);
  assign last_entry = (idx_r == POS_W'(STATE_WORDS - 1));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    prev_nxt  = prev_r;
    wr        = '0;
    done      = 1'b0;
    case (state_r)
      SD_IDLE: begin
        if (start) begin
          wr.en     = 1'b1;
          wr.addr   = '0;
          wr.data   = seed;
          prev_nxt  = seed;
          idx_nxt   = POS_W'(1);
          state_nxt = SD_MUL;
        end
      end
      SD_MUL: begin
        state_nxt = SD_ADD;
      end
      SD_ADD: begin
        wr.en    = 1'b1;
        wr.addr  = idx_r;
        wr.data  = entry;
        prev_nxt = entry;
        if (last_entry) begin
          done      = 1'b1;
          state_nxt = SD_IDLE;
        end else begin
          idx_nxt   = idx_r + POS_W'(1);
          state_nxt = SD_MUL;
        end
      end
      default: begin
        state_nxt = SD_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    prev_r <= prev_nxt;
    prod_r <= mix * INIT_MULT;
  end

endmodule

>>> rtl/core/mersenne_twister_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// mt19937 word generator with a 624-entry state ring in block memory
// ----------------------------------------------------------------------------
// Each request beat carries a reseed flag (in_tuser) and a burst count
// (in_tdata[6:0], counts above 64 act as 64); the block answers with that many
// tempered 32-bit words, the final one flagged by out_tlast. A reseed rewrites
// the whole ring from the seed register, writing the seed as entry zero and
// then one multiply step and one add-and-write step per entry after the first,
// and resets the position to zero. A burst then prefetches the ring in the
// prime and fetch states, then gives one word per cycle while the output is
// not stalled, paced by the ring memory doing one write and two reads each
// cycle. Output back-pressure stalls the twist. A new request is taken as soon
// as the last word of a burst has been loaded into the output register. The
// ring is undefined after reset, so the first request must reseed.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_assert.svh"

module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,  // seed_value
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [6:0] burst_count, [7] zero pad
  input  logic              in_tuser,     // reseed
  // word channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,    // random_word
  output logic              out_tlast     // last_word
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEED  = 5'b00010,
    S_PRIME = 5'b00100,
    S_FETCH = 5'b01000,
    S_TWIST = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [WORD_W-1:0]  seed_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   nxt_r, nxt_nxt;
  logic [POS_W-1:0]   mid_r, mid_nxt;
  logic [BURST_W-1:0] remaining_r, remaining_nxt;
  logic [WORD_W-1:0]  cur_r, cur_nxt;
  logic               out_valid_r;
  logic [WORD_W-1:0]  out_data_r;
  logic               out_last_r;

  logic               accept;
  logic               seed_start;
  logic               seed_done;
  mem_wr_t            seed_wr;
  mem_wr_t            ring_wr;
  logic               rd_en;
  logic [POS_W-1:0]   rd_addr_a;
  logic [POS_W-1:0]   rd_addr_b;
  logic [WORD_W-1:0]  rd_data_a;
  logic [WORD_W-1:0]  rd_data_b;
  logic [BURST_W-1:0] req_count;
  logic               out_free;
  logic               step;
  logic               last_step;
  logic [WORD_W-1:0]  mixed;
  logic [WORD_W-1:0]  twisted;

  // ring index helpers
  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] a);
    return (a == POS_W'(STATE_WORDS - 1)) ? '0 : a + POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] pos_mid(input logic [POS_W-1:0] a);
    return (a >= POS_W'(STATE_WORDS - MIDDLE_OFFSET))
           ? a - POS_W'(STATE_WORDS - MIDDLE_OFFSET)
           : a + POS_W'(MIDDLE_OFFSET);
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] y;
    y = v;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // handshakes
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign seed_start = accept && in_tuser;
  assign out_free   = !out_valid_r || out_tready;
  assign step       = (state_r == S_TWIST) && out_free;
  assign last_step  = step && (remaining_r == BURST_W'(1));
  assign req_count  = (in_tdata[BURST_W-1:0] > BURST_W'(MAX_BURST))
                      ? BURST_W'(MAX_BURST) : in_tdata[BURST_W-1:0];

  // twist: upper bit of the current entry, lower bits of the next one
  assign mixed   = {cur_r[WORD_W-1], rd_data_a[WORD_W-2:0]};
  assign twisted = rd_data_b ^ (mixed >> 1) ^ (mixed[0] ? TWIST_MATRIX : '0);

  // ring write select
  always_comb begin
    if (step) begin
      ring_wr.en   = 1'b1;
      ring_wr.addr = pos_r;
      ring_wr.data = twisted;
    end else begin
      ring_wr = seed_wr;
    end
  end

  // sequencer and read address generation
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    nxt_nxt       = nxt_r;
    mid_nxt       = mid_r;
    remaining_nxt = remaining_r;
    cur_nxt       = cur_r;
    rd_en         = 1'b0;
    rd_addr_a     = pos_r;
    rd_addr_b     = pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          remaining_nxt = req_count;
          if (in_tuser) begin
            state_nxt = S_SEED;
          end else if (req_count != '0) begin
            state_nxt = S_PRIME;
          end
        end
      end
      S_SEED: begin
        if (seed_done) begin
          pos_nxt   = '0;
          state_nxt = (remaining_r != '0) ? S_PRIME : S_IDLE;
        end
      end
      S_PRIME: begin
        rd_en     = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cur_nxt   = rd_data_a;
        rd_en     = 1'b1;
        rd_addr_a = pos_inc(pos_r);
        rd_addr_b = pos_mid(pos_r);
        nxt_nxt   = rd_addr_a;
        mid_nxt   = rd_addr_b;
        state_nxt = S_TWIST;
      end
      S_TWIST: begin
        if (step) begin
          cur_nxt       = rd_data_a;
          pos_nxt       = nxt_r;
          remaining_nxt = remaining_r - BURST_W'(1);
          if (last_step) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr_a = pos_inc(nxt_r);
            rd_addr_b = pos_inc(mid_r);
            nxt_nxt   = rd_addr_a;
            mid_nxt   = rd_addr_b;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= SEED_RESET;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      remaining_r <= remaining_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    nxt_r <= nxt_nxt;
    mid_r <= mid_nxt;
    cur_r <= cur_nxt;
    if (step) begin
      out_data_r <= temper(twisted);
      out_last_r <= last_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ring initialisation
  mtg_seed_unit u_seed (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seed_start),
    .seed  (seed_r),
    .wr    (seed_wr),
    .done  (seed_done)
  );

  // state ring
  mtg_ring_mem u_ring (
    .clk       (clk),
    .wr        (ring_wr),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // checks
  `MTG_ASSERT_IMP(a_pos_range, 1'b1, pos_r < POS_W'(STATE_WORDS), "ring position out of range")
  `MTG_ASSERT_IMP(a_twist_addr, state_r == S_TWIST,
    nxt_r == pos_inc(pos_r) && mid_r == pos_mid(pos_r), "twist read addresses out of step")
  `MTG_ASSERT_NXT(a_last_word, last_step,
    state_r == S_IDLE && out_tvalid && out_tlast, "burst end not flagged")
  `MTG_ASSERT_NXT(a_burst_runs, step && !last_step,
    state_r == S_TWIST && !out_tlast, "burst stopped early")
  `MTG_ASSERT_IMP(a_seed_done, seed_done, state_r == S_SEED, "seed fill ended outside reseed")

endmodule
